FILE: hw/rtl/udw_pkg.sv
// ----------------------------------------------------------------------------
// udw_pkg
// Shared types, constants and the lead byte classifier of the UTF-8 decoder.
// ----------------------------------------------------------------------------
package udw_pkg;

    // Field widths.
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CP_W   = 21;
    localparam int unsigned CP1_W  = 11;

    // Surrogate pair constants.
    localparam logic [CP_W-1:0] SUPP_BASE = 21'h10000;
    localparam logic [15:0]     HI_BASE   = 16'hD800;
    localparam logic [5:0]      LO_PREFIX = 6'b110111;

    // Lead byte classes; the value of a multi-byte class is its follow count.
    typedef enum logic [2:0] {
        LK_ASCII   = 3'd0,
        LK_NEED1   = 3'd1,
        LK_NEED2   = 3'd2,
        LK_NEED3   = 3'd3,
        LK_INVALID = 3'd4
    } t_lead_kind;

    // One queue entry: one or two code points caused by one input byte.
    // The second code point only comes from a truncated tail, so it is narrow.
    typedef struct packed {
        logic [CP_W-1:0]  cp0;
        logic             has_cp1;
        logic [CP1_W-1:0] cp1;
    } t_cp_entry;

    // Write side of the queue.
    typedef struct packed {
        logic      push;
        t_cp_entry entry;
    } t_q_wr;

    // Classify a byte met in lead position.
    function automatic t_lead_kind lead_kind(input logic [BYTE_W-1:0] c);
        t_lead_kind k;
        if (c[7] == 1'b0) begin
            k = LK_ASCII;
        end else if (c[7:5] == 3'b110) begin
            k = LK_NEED1;
        end else if (c[7:4] == 4'b1110) begin
            k = LK_NEED2;
        end else if (c[7:3] == 5'b11110) begin
            k = LK_NEED3;
        end else begin
            k = LK_INVALID;
        end
        return k;
    endfunction

endpackage

FILE: hw/rtl/udw_front.sv
// ----------------------------------------------------------------------------
// udw_front
// Accepts stream bytes, tracks the pending sequence and pushes the decoded
// code points of each byte into the queue.
// ----------------------------------------------------------------------------
module udw_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [udw_pkg::BYTE_W-1:0]  i_byte_value,
    input  logic                        i_final_byte,
    input  logic                        i_queue_full,
    output logic                        o_stall,
    output udw_pkg::t_q_wr              o_q_wr
);

    // Pending sequence state.
    logic [udw_pkg::BYTE_W-1:0] r_lead, n_lead;
    logic [1:0]                 r_held, n_held;
    logic [1:0]                 r_needed, n_needed;
    logic [udw_pkg::BYTE_W-1:0] r_cont [2];

    logic                  accept;
    logic                  cont_we;
    logic                  complete;
    logic [4:0]            lead_bits;
    logic [2:0]            kind_bits;
    udw_pkg::t_lead_kind   b_kind;
    udw_pkg::t_lead_kind   c0_kind;
    logic [22:0]           cp_full;
    udw_pkg::t_q_wr        q_wr;

    assign o_stall = i_queue_full;
    assign accept  = i_valid && !i_queue_full;
    assign b_kind  = udw_pkg::lead_kind(i_byte_value);
    assign c0_kind = udw_pkg::lead_kind(r_cont[0]);
    assign kind_bits = 3'(b_kind);
    assign complete  = (({1'b0, r_held} + 3'd1) >= {1'b0, r_needed});

    // Payload bits of the held lead byte.
    always_comb begin
        case (r_needed)
            2'd1:    lead_bits = r_lead[4:0];
            2'd2:    lead_bits = {1'b0, r_lead[3:0]};
            default: lead_bits = {2'b00, r_lead[2:0]};
        endcase
    end

    // Assemble a completed code point from lead, held bytes and this byte.
    always_comb begin
        case (r_held)
            2'd0:    cp_full = {12'd0, lead_bits, i_byte_value[5:0]};
            2'd1:    cp_full = {6'd0, lead_bits, r_cont[0][5:0], i_byte_value[5:0]};
            default: cp_full = {lead_bits, r_cont[0][5:0], r_cont[1][5:0],
                                i_byte_value[5:0]};
        endcase
    end

    // Sequence tracking and queue entry generation.
    always_comb begin
        n_lead   = r_lead;
        n_held   = r_held;
        n_needed = r_needed;
        cont_we  = 1'b0;
        q_wr     = '0;
        if (accept) begin
            if (r_needed == 2'd0) begin
                if (b_kind == udw_pkg::LK_ASCII) begin
                    q_wr.push      = 1'b1;
                    q_wr.entry.cp0 = {13'd0, i_byte_value};
                end else if (b_kind != udw_pkg::LK_INVALID && !i_final_byte) begin
                    n_lead   = i_byte_value;
                    n_needed = kind_bits[1:0];
                    n_held   = 2'd0;
                end
            end else if (complete) begin
                q_wr.push      = 1'b1;
                q_wr.entry.cp0 = cp_full[udw_pkg::CP_W-1:0];
                n_lead   = '0;
                n_held   = 2'd0;
                n_needed = 2'd0;
            end else if (i_final_byte) begin
                // Truncated sequence: the held bytes are decoded as fresh leads.
                if (r_held == 2'd0) begin
                    if (b_kind == udw_pkg::LK_ASCII) begin
                        q_wr.push      = 1'b1;
                        q_wr.entry.cp0 = {13'd0, i_byte_value};
                    end
                end else if (c0_kind == udw_pkg::LK_ASCII) begin
                    q_wr.push      = 1'b1;
                    q_wr.entry.cp0 = {13'd0, r_cont[0]};
                    if (b_kind == udw_pkg::LK_ASCII) begin
                        q_wr.entry.has_cp1 = 1'b1;
                        q_wr.entry.cp1     = {3'd0, i_byte_value};
                    end
                end else if (c0_kind == udw_pkg::LK_NEED1) begin
                    q_wr.push      = 1'b1;
                    q_wr.entry.cp0 = {10'd0, r_cont[0][4:0], i_byte_value[5:0]};
                end else if (b_kind == udw_pkg::LK_ASCII) begin
                    q_wr.push      = 1'b1;
                    q_wr.entry.cp0 = {13'd0, i_byte_value};
                end
            end else begin
                cont_we = 1'b1;
                n_held  = r_held + 2'd1;
            end
            // The end of a string leaves nothing pending.
            if (i_final_byte) begin
                n_lead   = '0;
                n_held   = 2'd0;
                n_needed = 2'd0;
            end
        end
    end

    assign o_q_wr = q_wr;

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead   <= '0;
            r_held   <= 2'd0;
            r_needed <= 2'd0;
        end else begin
            r_lead   <= n_lead;
            r_held   <= n_held;
            r_needed <= n_needed;
        end
    end

    // Held following bytes.
    always_ff @(posedge i_clk) begin
        if (cont_we) begin
            r_cont[r_held[0]] <= i_byte_value;
        end
    end

endmodule

FILE: hw/rtl/udw_queue.sv
// ----------------------------------------------------------------------------
// udw_queue
// Two-entry queue of decoded code points between the front and back parts.
// ----------------------------------------------------------------------------
module udw_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  udw_pkg::t_q_wr     i_q_wr,
    input  logic               i_pop,
    output logic               o_full,
    output logic               o_nonempty,
    output udw_pkg::t_cp_entry o_head
);

    udw_pkg::t_cp_entry r_mem [2];
    logic               r_wr_ptr;
    logic               r_rd_ptr;
    logic [1:0]         r_count, n_count;

    assign o_full     = (r_count == 2'd2);
    assign o_nonempty = (r_count != 2'd0);
    assign o_head     = r_mem[r_rd_ptr];

    // Occupancy follows pushes and pops.
    always_comb begin
        n_count = r_count;
        if (i_q_wr.push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_q_wr.push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    // Pointers and count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_q_wr.push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= n_count;
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_q_wr.push) begin
            r_mem[r_wr_ptr] <= i_q_wr.entry;
        end
    end

endmodule

FILE: hw/rtl/udw_back.sv
// ----------------------------------------------------------------------------
// udw_back
// Expands queued code points into output units, splitting supplementary
// code points into surrogate pairs in UTF-16 mode, and holds the output word.
// ----------------------------------------------------------------------------
module udw_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_utf16_mode,
    input  logic                      i_nonempty,
    input  udw_pkg::t_cp_entry        i_head,
    input  logic                      i_stall,
    output logic                      o_pop,
    output logic                      o_valid,
    output logic [udw_pkg::CP_W-1:0]  o_code_unit,
    output logic                      o_run_end
);

    logic                     r_phase, n_phase;
    logic                     r_valid;
    logic [udw_pkg::CP_W-1:0] r_code_unit;
    logic                     r_run_end;

    logic                     split;
    logic                     load;
    logic                     last;
    logic [udw_pkg::CP_W-1:0] v;
    logic [udw_pkg::CP_W-1:0] hi_unit;
    logic [udw_pkg::CP_W-1:0] lo_unit;
    logic [udw_pkg::CP_W-1:0] unit;

    // Surrogate pair arithmetic.
    assign split   = i_utf16_mode && (i_head.cp0 >= udw_pkg::SUPP_BASE);
    assign v       = i_head.cp0 - udw_pkg::SUPP_BASE;
    assign hi_unit = {5'd0, udw_pkg::HI_BASE + {5'd0, v[20:10]}};
    assign lo_unit = {5'd0, udw_pkg::LO_PREFIX, v[9:0]};

    // Pick the unit for the current phase of the head entry.
    always_comb begin
        if (!r_phase) begin
            unit = split ? hi_unit : i_head.cp0;
            last = !split && !i_head.has_cp1;
        end else begin
            unit = split ? lo_unit : {10'd0, i_head.cp1};
            last = 1'b1;
        end
    end

    assign load    = i_nonempty && (!r_valid || !i_stall);
    assign o_pop   = load && last;
    assign n_phase = load ? !last : r_phase;

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            if (load) begin
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Output word.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_code_unit <= unit;
            r_run_end   <= last;
        end
    end

    assign o_valid     = r_valid;
    assign o_code_unit = r_code_unit;
    assign o_run_end   = r_run_end;

endmodule

FILE: hw/rtl/utf8_decoder_wide_units.sv
// ----------------------------------------------------------------------------
// utf8_decoder_wide_units
// Streaming UTF-8 decoder that emits code points or UTF-16 units.
// ----------------------------------------------------------------------------
// Input channel: one byte of the UTF-8 stream per word (i_byte_value), with
// i_final_byte set on the last byte of a string. A word is taken at a clock
// edge where i_valid is high and o_stall is low.
// Output channel: one code point, or one UTF-16 unit when utf16_mode is set,
// per word; o_run_end marks the last unit caused by one input byte. The
// receiver holds i_stall high to keep the current word in place.
// Configuration: a write on i_cfg_valid (o_cfg_ready is always high) sets
// utf16_mode from i_cfg_data. Write it only while the block is idle.
// A unit is registered in the queue and then in the output word.
// Throughput: one byte per cycle while o_stall is low. A byte that yields two
// units (a surrogate pair or a truncated tail) occupies the output with both;
// a two-entry queue absorbs this, and o_stall rises only when it is full.
// Reset (synchronous, i_rst_n low) clears the pending sequence, the queue,
// the output valid flag and the mode register; no clearing pass is needed.
// ----------------------------------------------------------------------------
module utf8_decoder_wide_units (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [udw_pkg::BYTE_W-1:0]  i_byte_value,
    input  logic                        i_final_byte,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [udw_pkg::CP_W-1:0]    o_code_unit,
    output logic                        o_run_end,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic                        i_cfg_data
);

    logic               r_utf16_mode;
    logic               queue_full;
    logic               queue_nonempty;
    logic               pop;
    udw_pkg::t_q_wr     q_wr;
    udw_pkg::t_cp_entry head;

    // Mode register.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_utf16_mode <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_utf16_mode <= i_cfg_data;
        end
    end

    // Byte intake and sequence tracking.
    udw_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_byte_value (i_byte_value),
        .i_final_byte (i_final_byte),
        .i_queue_full (queue_full),
        .o_stall      (o_stall),
        .o_q_wr       (q_wr)
    );

    // Decoupling queue.
    udw_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_wr     (q_wr),
        .i_pop      (pop),
        .o_full     (queue_full),
        .o_nonempty (queue_nonempty),
        .o_head     (head)
    );

    // Unit expansion and output word.
    udw_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_utf16_mode (r_utf16_mode),
        .i_nonempty   (queue_nonempty),
        .i_head       (head),
        .i_stall      (i_stall),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .o_code_unit  (o_code_unit),
        .o_run_end    (o_run_end)
    );

endmodule

FILE: bench/utf8_decoder_wide_units_tb.sv
// ----------------------------------------------------------------------------
// utf8_decoder_wide_units_tb
// Self-checking bench for the streaming UTF-8 to wide unit decoder.
// ----------------------------------------------------------------------------
// Bytes go in one word at a time through the valid/stall input channel. As
// each byte is taken, a behavioral decoder in the bench works out the units
// that byte must cause. Those units are queued in order, and every output
// word is checked against the oldest one. The run starts with hand-picked
// strings: ASCII, invalid leads, overlong and unchecked continuations,
// truncated tails and surrogate pairs. It then sends random well-formed
// strings mixed with broken strings and noise, in both output modes, under
// three idling patterns. A long receiver hold at the end fills the block.
// ----------------------------------------------------------------------------
module utf8_decoder_wide_units_tb;

    localparam int unsigned CW = udw_pkg::CP_W;
    localparam int unsigned BW = udw_pkg::BYTE_W;

    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          HOLD_CYCLES  = 60;
    localparam int          SETTLE_TICKS = 4;
    localparam logic [31:0] SUPP_START   = 32'h10000;
    localparam logic [31:0] HIGH_BASE    = 32'hD800;
    localparam logic [31:0] LOW_BASE     = 32'hDC00;
    localparam logic [31:0] LOW_MASK     = 32'h3FF;
    localparam int          NEED_INVALID = 4;

    // One expected output word.
    typedef struct packed {
        logic [CW-1:0] unit;
        logic          last;
    } t_unit_word;

    logic          i_clk        = 1'b0;
    logic          i_rst_n      = 1'b0;
    logic          i_valid      = 1'b0;
    logic          o_stall;
    logic [BW-1:0] i_byte_value = '0;
    logic          i_final_byte = 1'b0;
    logic          o_valid;
    logic          i_stall      = 1'b0;
    logic [CW-1:0] o_code_unit;
    logic          o_run_end;
    logic          i_cfg_valid  = 1'b0;
    logic          o_cfg_ready;
    logic          i_cfg_data   = 1'b0;

    // Decoder state mirrored by the bench.
    logic          utf16_q = 1'b0;
    logic [7:0]    lead_q  = 8'd0;
    logic [7:0]    cont_q [0:1] = '{8'd0, 8'd0};
    int            held_q  = 0;
    int            need_q  = 0;
    logic [7:0]    tail_bytes [0:2];

    logic [CW-1:0] burst [$];
    t_unit_word    expected_units [$];
    logic [7:0]    text_bytes [$];
    t_unit_word    want;

    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    logic hold_rx      = 1'b0;
    int  fault_count   = 0;
    int  bytes_sent    = 0;
    int  units_seen    = 0;
    int  cycle_count   = 0;

    utf8_decoder_wide_units i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_byte_value (i_byte_value),
        .i_final_byte (i_final_byte),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_code_unit  (o_code_unit),
        .o_run_end    (o_run_end),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // Number of continuation bytes a lead asks for; NEED_INVALID for a bad lead.
    function automatic int follow_count(input logic [7:0] c);
        if (c < 8'h80) return 0;
        if ((c & 8'hE0) == 8'hC0) return 1;
        if ((c & 8'hF0) == 8'hE0) return 2;
        if ((c & 8'hF8) == 8'hF0) return 3;
        return NEED_INVALID;
    endfunction

    function automatic logic [31:0] lead_payload(input logic [7:0] c, input int nd);
        if (nd == 1) return {24'd0, c & 8'h1F};
        if (nd == 2) return {24'd0, c & 8'h0F};
        return {24'd0, c & 8'h07};
    endfunction

    // Append one code point to the units of the current byte, split into a
    // surrogate pair in UTF-16 mode.
    task automatic push_unit(input logic [31:0] cp);
        logic [31:0] offset;
        logic [31:0] half;
        if (utf16_q && cp >= SUPP_START && burst.size() <= 1) begin
            offset = cp - SUPP_START;
            half   = HIGH_BASE + (offset >> 10);
            burst.insert(burst.size(), half[CW-1:0]);
            half   = LOW_BASE + (offset & LOW_MASK);
            burst.insert(burst.size(), half[CW-1:0]);
        end else if (burst.size() <= 2) begin
            burst.insert(burst.size(), cp[CW-1:0]);
        end
    endtask

    task automatic clear_pending();
        lead_q = 8'd0;
        held_q = 0;
        need_q = 0;
    endtask

    // Re-decode the bytes left over when a string ends mid-sequence.
    task automatic decode_tail(input int count);
        int          pos;
        int          nd;
        int          k;
        logic [31:0] cp;
        pos = 0;
        while (pos < count) begin
            nd = follow_count(tail_bytes[pos]);
            if (nd == 0) begin
                push_unit({24'd0, tail_bytes[pos]});
                pos++;
            end else if (nd < NEED_INVALID && pos + nd < count) begin
                cp = lead_payload(tail_bytes[pos], nd);
                for (k = 1; k <= nd; k++) cp = (cp << 6) | tail_bytes[pos + k][5:0];
                push_unit(cp);
                pos += nd + 1;
            end else begin
                pos++;
            end
        end
    endtask

    // Work out the units one accepted byte causes and queue them.
    task automatic decode_byte(input logic [7:0] b, input logic fin);
        int          nd;
        int          k;
        logic [31:0] cp;
        t_unit_word  word_item;
        burst.delete();
        if (need_q == 0) begin
            nd = follow_count(b);
            if (nd == 0) begin
                push_unit({24'd0, b});
            end else if (nd < NEED_INVALID && !fin) begin
                lead_q = b;
                need_q = nd;
                held_q = 0;
            end
        end else if (held_q + 1 >= need_q || held_q >= 2) begin
            cp = lead_payload(lead_q, need_q);
            for (k = 0; k < held_q; k++) cp = (cp << 6) | cont_q[k][5:0];
            cp = (cp << 6) | b[5:0];
            push_unit(cp);
            clear_pending();
        end else if (fin) begin
            for (k = 0; k < held_q; k++) tail_bytes[k] = cont_q[k];
            tail_bytes[held_q] = b;
            k = held_q + 1;
            clear_pending();
            decode_tail(k);
        end else begin
            cont_q[held_q] = b;
            held_q++;
        end
        if (fin) clear_pending();
        for (k = 0; k < burst.size(); k++) begin
            word_item.unit = burst[k];
            word_item.last = (k == burst.size() - 1);
            expected_units.insert(expected_units.size(), word_item);
        end
    endtask

    // Offer one byte, idling first at random, and wait until it is taken.
    // Valid stays high afterwards so that a following word can go out
    // back to back.
    task automatic send_byte(input logic [7:0] b, input logic fin);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_byte_value <= b;
        i_final_byte <= fin;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        decode_byte(b, fin);
        bytes_sent++;
    endtask

    // Send the collected string with the final flag on its last byte.
    task automatic send_text();
        int k;
        for (k = 0; k < text_bytes.size(); k++) begin
            send_byte(text_bytes[k], k == text_bytes.size() - 1);
        end
    endtask

    // Append the first keep bytes of a random sequence of len bytes.
    // A continuation is now and then an arbitrary byte, since none is checked.
    task automatic build_sequence(input int len, input int keep);
        logic [7:0] b;
        int         k;
        case (len)
            1: begin
                b = 8'($urandom_range(127));
            end
            2: begin
                b = 8'hC0 | 8'($urandom_range(31));
            end
            3: begin
                b = 8'hE0 | 8'($urandom_range(15));
            end
            default: begin
                b = 8'hF0 | 8'($urandom_range(7));
            end
        endcase
        text_bytes.insert(text_bytes.size(), b);
        for (k = 1; k < keep; k++) begin
            if ($urandom_range(9) == 0) b = 8'($urandom_range(255));
            else b = 8'h80 | 8'($urandom_range(63));
            text_bytes.insert(text_bytes.size(), b);
        end
    endtask

    // A string of whole sequences; a broken one ends inside a sequence.
    task automatic send_random_string(input bit broken);
        int nseq;
        int len;
        int s;
        text_bytes.delete();
        nseq = $urandom_range(1, 5);
        for (s = 0; s < nseq; s++) begin
            len = $urandom_range(1, 4);
            build_sequence(len, len);
        end
        if (broken) begin
            len = $urandom_range(2, 4);
            build_sequence(len, $urandom_range(1, len - 1));
        end
        send_text();
    endtask

    // Wait until every expected unit has come, then a few cycles more.
    task automatic drain_units();
        i_valid <= 1'b0;
        while (expected_units.size() != 0) @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic mode);
        drain_units();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= mode;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        utf16_q = mode;
    endtask

    // ASCII extremes and both ranges of invalid leads.
    task automatic test_single_bytes();
        send_byte(8'h00, 1'b1);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hFF, 1'b1);
    endtask

    // Whole sequences, overlong and unchecked forms, and a lead on the final byte.
    task automatic test_multibyte_points();
        send_byte(8'hC2, 1'b0);
        send_byte(8'hA9, 1'b0);
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b0);
        send_byte(8'hAC, 1'b0);
        send_byte(8'hC0, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hC3, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'hE2, 1'b1);
    endtask

    // Strings that end mid-sequence: the held bytes are decoded as fresh
    // leads, and a fresh lead short of bytes is dropped.
    task automatic test_truncated_tails();
        send_byte(8'hF0, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'h42, 1'b1);
        send_byte(8'hF0, 1'b0);
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b1);
    endtask

    // UTF-16 mode: a BMP point passes whole, the largest point gives a pair
    // whose first unit lies above the high surrogate range.
    task automatic test_surrogate_pairs();
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b0);
        send_byte(8'hAC, 1'b0);
        send_byte(8'hF7, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b1);
    endtask

    // Mostly well-formed strings, some broken strings and some noise bytes.
    task automatic run_random_traffic(input int budget);
        int         counted;
        int         pick;
        logic [7:0] noise;
        counted = 0;
        while (counted < budget) begin
            pick = $urandom_range(99);
            if (pick < 10) begin
                noise = 8'($urandom_range(255));
                send_byte(noise, 1'($urandom_range(1)));
                counted++;
            end else begin
                send_random_string(pick < 30);
                counted += text_bytes.size();
            end
        end
    endtask

    // Hold the receiver off while four-byte sequences keep coming, so that
    // surrogate pairs fill the block and it stalls its input.
    task automatic test_output_backpressure();
        int s;
        fork
            begin
                hold_rx <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_rx <= 1'b0;
            end
        join_none
        text_bytes.delete();
        for (s = 0; s < 8; s++) build_sequence(4, 4);
        send_text();
    endtask

    // Receiver: random stall, and each taken word checked against the oldest
    // expected unit.
    always @(posedge i_clk) begin
        i_stall <= hold_rx || ($urandom_range(99) < recv_idle_pct);
        if (i_rst_n && o_valid && !i_stall) begin
            units_seen++;
            if (expected_units.size() == 0) begin
                if (fault_count < 10) begin
                    $display("unexpected word: unit %h run_end %b", o_code_unit, o_run_end);
                end
                fault_count++;
            end else begin
                want = expected_units.pop_front();
                if (o_code_unit !== want.unit || o_run_end !== want.last) begin
                    if (fault_count < 10) begin
                        $display("word mismatch: expected unit %h run_end %b, got unit %h run_end %b",
                                 want.unit, want.last, o_code_unit, o_run_end);
                    end
                    fault_count++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("[utf8_decoder_wide_units] ERROR");
        $finish;
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 16;
        recv_idle_pct = 53;
        test_single_bytes();
        test_multibyte_points();
        test_truncated_tails();
        run_random_traffic(115);

        write_mode(1'b1);
        send_idle_pct = 53;
        recv_idle_pct = 16;
        test_surrogate_pairs();
        run_random_traffic(115);

        write_mode(1'b0);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random_traffic(115);

        write_mode(1'b1);
        test_output_backpressure();
        drain_units();

        if (expected_units.size() != 0) fault_count++;
        $display("Covered %0d bytes and %0d output words in code point and UTF-16 modes,",
                 bytes_sent, units_seen);
        $display("with idling on both sides and a long receiver hold; %0d faults.", fault_count);
        if (fault_count == 0) begin
            $display("[utf8_decoder_wide_units] OK");
        end else begin
            $display("[utf8_decoder_wide_units] ERROR");
        end
        $finish;
    end

endmodule

FILE: utf8_decoder_wide_units.f
hw/rtl/udw_pkg.sv
hw/rtl/udw_front.sv
hw/rtl/udw_queue.sv
hw/rtl/udw_back.sv
hw/rtl/utf8_decoder_wide_units.sv
bench/utf8_decoder_wide_units_tb.sv
